// ===== rtl/core/pcr_pkg.sv =====
// Types, constants and helpers shared by the collision response pipeline.
`timescale 1ns / 1ps
`default_nettype none
package pcr_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned NORM_BITS = 29;
  localparam int unsigned DIFF_W    = WORD_W + 1;
  localparam int unsigned NRM_W     = 31;
  localparam int unsigned SQ_W      = 2 * NRM_W;
  localparam int unsigned RAD_W     = 64;
  localparam int unsigned ROOT_W    = 32;
  localparam int unsigned SREM_W    = 36;
  localparam int unsigned QUO_W     = 30;
  localparam int unsigned DREM_W    = 33;
  localparam int unsigned NVEC_W    = QUO_W + 1;
  localparam int unsigned RV_W      = WORD_W + 1;
  localparam int unsigned PROD_W    = RV_W + NVEC_W;
  localparam int unsigned DOT_W     = PROD_W + 1;
  localparam int unsigned SPD_W     = DOT_W - NORM_BITS;
  localparam int unsigned MAG_W     = 35;
  localparam int unsigned REST_W    = 17;
  localparam int unsigned MINSPD_W  = 16;
  localparam int unsigned K_W       = 18;
  localparam int unsigned RIMP_W    = MAG_W + K_W - REST_W;
  localparam int unsigned RPART_W   = RIMP_W / 2;
  localparam int unsigned PPART_W   = RPART_W + 1 + NVEC_W;
  localparam int unsigned DSUM_W    = PPART_W + RPART_W;
  localparam int unsigned DD_W      = DSUM_W - NORM_BITS;
  localparam int unsigned VSUM_W    = DD_W + 1;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  localparam int unsigned N_NORM = 5;
  localparam int unsigned N_SQRT = 32;
  localparam int unsigned N_DIV  = 30;

  // Stage positions along the pipeline
  localparam int unsigned ST_AB       = N_NORM + 2;
  localparam int unsigned ST_SQRT_END = ST_AB + 1 + N_SQRT;
  localparam int unsigned ST_DIV_END  = ST_SQRT_END + N_DIV;
  localparam int unsigned ST_N        = ST_DIV_END + 1;
  localparam int unsigned ST_OUT      = ST_N + 3;
  localparam int unsigned PIPE_LAT    = ST_OUT + 4;

  localparam logic [REST_W-1:0]   REST_RESET   = 17'd58982;
  localparam logic [MINSPD_W-1:0] MINSPD_RESET = 16'd66;
  localparam logic [K_W-1:0]      REST_ONE     = 18'd65536;

  typedef enum logic [1:0] {
    OUT_IMPULSE    = 2'd0,
    OUT_COINCIDENT = 2'd1,
    OUT_SEPARATING = 2'd2
  } outcome_e;

  typedef enum logic {
    REG_RESTITUTION = 1'b0,
    REG_MIN_SPEED   = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [WORD_W-1:0] first_pos_x;
    logic signed [WORD_W-1:0] first_pos_y;
    logic signed [WORD_W-1:0] second_pos_x;
    logic signed [WORD_W-1:0] second_pos_y;
    logic signed [WORD_W-1:0] first_vel_x;
    logic signed [WORD_W-1:0] first_vel_y;
    logic signed [WORD_W-1:0] second_vel_x;
    logic signed [WORD_W-1:0] second_vel_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] new_first_vel_x;
    logic signed [WORD_W-1:0] new_first_vel_y;
    logic signed [WORD_W-1:0] new_second_vel_x;
    logic signed [WORD_W-1:0] new_second_vel_y;
    logic [1:0]               outcome;
  } out_beat_t;

  typedef struct packed {
    logic [NRM_W-1:0] a;
    logic [NRM_W-1:0] b;
    logic [NRM_W-1:0] m;
  } norm_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [DREM_W-1:0] rem_x;
    logic [DREM_W-1:0] rem_y;
    logic [QUO_W-1:0]  q_x;
    logic [QUO_W-1:0]  q_y;
    logic [ROOT_W-1:0] divisor;
  } div_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] v1x;
    logic signed [WORD_W-1:0] v1y;
    logic signed [WORD_W-1:0] v2x;
    logic signed [WORD_W-1:0] v2y;
    logic                     sx;
    logic                     sy;
    outcome_e                 outcome;
    logic [NRM_W-1:0]         a;
    logic [NRM_W-1:0]         b;
    logic signed [NVEC_W-1:0] nx;
    logic signed [NVEC_W-1:0] ny;
  } side_t;

  // Clip a widened sum back into the signed word range
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [VSUM_W-1:0] v);
    logic top_ones;
    logic top_zeros;
    top_ones  = &v[VSUM_W-1:WORD_W-1];
    top_zeros = ~|v[VSUM_W-1:WORD_W-1];
    if (v[VSUM_W-1] && !top_ones) begin
      sat_word = {1'b1, {(WORD_W-1){1'b0}}};
    end else if (!v[VSUM_W-1] && !top_zeros) begin
      sat_word = {1'b0, {(WORD_W-1){1'b1}}};
    end else begin
      sat_word = v[WORD_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/particle_collision_response_top.sv =====
// Top level of the equal-mass particle collision response pipeline.
// One beat in carries a colliding pair (positions and velocities, signed Q16.16);
// one beat out carries the updated velocities and an outcome code. The block
// takes one beat per clock while in_stall_o is low and shows each result in the
// output register: the beat enters the first of 78 pipeline stages at the edge
// that takes it (separation, magnitudes, 5 normalizing cells, squares and
// their sum, 32 square root cells, 30 divider cells, then signed normal, two dot
// product stages, speed clamp, impulse, partial products and delta), and the
// output register loads it from the last stage. The square root and divider
// chains, one result bit per cell, set that depth. A skid register behind the
// output register absorbs one beat when the sink stalls; in_stall_o rises only
// while that skid register is full, and the whole pipeline holds with it.
// Restitution and the minimum approach speed are to be written over the APB
// port only while idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module particle_collision_response_top import pcr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_beat_t           in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_beat_t          out_beat_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // ---------------------------------------------------------------- config
  logic [REST_W-1:0]   rest_q;
  logic [MINSPD_W-1:0] minspd_q;
  reg_idx_e            reg_idx;

  assign reg_idx = reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q   <= REST_RESET;
      minspd_q <= MINSPD_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_RESTITUTION: rest_q   <= pwdata[REST_W-1:0];
        REG_MIN_SPEED:   minspd_q <= pwdata[MINSPD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RESTITUTION: prdata = {{(PDATA_W-REST_W){1'b0}}, rest_q};
      REG_MIN_SPEED:   prdata = {{(PDATA_W-MINSPD_W){1'b0}}, minspd_q};
      default:         prdata = '0;
    endcase
  end

  // ------------------------------------------------------- pipeline control
  // The whole pipeline advances together unless the skid register is full.
  logic                en;
  logic                skid_q;
  logic                out_valid_q;
  logic [PIPE_LAT-1:0] vld_q;
  side_t               side_q [PIPE_LAT];
  side_t               side_d [PIPE_LAT];

  assign en         = !skid_q;
  assign in_stall_o = skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_valid_i};
    end
  end

  // --------------------------------------------- stage 0: separation vector
  logic signed [DIFF_W-1:0] dx_q;
  logic signed [DIFF_W-1:0] dy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= DIFF_W'(in_beat_i.first_pos_x) - DIFF_W'(in_beat_i.second_pos_x);
      dy_q <= DIFF_W'(in_beat_i.first_pos_y) - DIFF_W'(in_beat_i.second_pos_y);
    end
  end

  // ------------------------------- stage 1: magnitudes, coarse right shift
  logic [DIFF_W-1:0] ax;
  logic [DIFF_W-1:0] ay;
  logic [DIFF_W-1:0] amax;
  norm_t             nrm1_d;
  logic              coinc;

  always_comb begin
    ax    = dx_q[DIFF_W-1] ? DIFF_W'(-dx_q) : DIFF_W'(dx_q);
    ay    = dy_q[DIFF_W-1] ? DIFF_W'(-dy_q) : DIFF_W'(dy_q);
    amax  = (ax > ay) ? ax : ay;
    coinc = (dx_q == '0) && (dy_q == '0);
    // Bring the larger magnitude below 2^31 (truncating)
    priority if (amax[DIFF_W-1]) begin
      nrm1_d.a = NRM_W'(ax >> 2);
      nrm1_d.b = NRM_W'(ay >> 2);
      nrm1_d.m = NRM_W'(amax >> 2);
    end else if (amax[DIFF_W-2]) begin
      nrm1_d.a = NRM_W'(ax >> 1);
      nrm1_d.b = NRM_W'(ay >> 1);
      nrm1_d.m = NRM_W'(amax >> 1);
    end else begin
      nrm1_d.a = NRM_W'(ax);
      nrm1_d.b = NRM_W'(ay);
      nrm1_d.m = NRM_W'(amax);
    end
  end

  norm_t nrm [N_NORM+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      nrm[0] <= nrm1_d;
    end
  end

  // -------------------------------- stages 2..6: exact left normalization
  for (genvar k = 0; k < N_NORM; k++) begin : g_norm
    pcr_norm_cell #(
      .SHIFT(1 << (N_NORM - 1 - k))
    ) u_norm (
      .clk_i (clk_i),
      .en_i  (en),
      .nrm_i (nrm[k]),
      .nrm_o (nrm[k+1])
    );
  end

  // ------------------------------------ stages 7, 8: sum of the squares
  logic [SQ_W-1:0] sqx_q;
  logic [SQ_W-1:0] sqy_q;
  logic [SQ_W:0]   sum_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q <= SQ_W'(nrm[N_NORM].a) * SQ_W'(nrm[N_NORM].a);
      sqy_q <= SQ_W'(nrm[N_NORM].b) * SQ_W'(nrm[N_NORM].b);
      sum_q <= {1'b0, sqx_q} + {1'b0, sqy_q};
    end
  end

  // ---------------------------- stages 9..40: floor square root, bit per cell
  sqrt_t sq [N_SQRT+1];

  assign sq[0] = '{rad: {{(RAD_W-SQ_W-1){1'b0}}, sum_q}, rem: '0, root: '0};

  for (genvar k = 0; k < N_SQRT; k++) begin : g_sqrt
    pcr_sqrt_cell u_sqrt (
      .clk_i (clk_i),
      .en_i  (en),
      .sq_i  (sq[k]),
      .sq_o  (sq[k+1])
    );
  end

  // ------------------------- stages 41..70: normal = |component| / distance
  div_t dv [N_DIV+1];

  assign dv[0] = '{rem_x:   {{(DREM_W-NRM_W){1'b0}}, side_q[ST_SQRT_END].a},
                   rem_y:   {{(DREM_W-NRM_W){1'b0}}, side_q[ST_SQRT_END].b},
                   q_x:     '0,
                   q_y:     '0,
                   divisor: sq[N_SQRT].root};

  for (genvar k = 0; k < N_DIV; k++) begin : g_div
    pcr_div_cell u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .dv_i  (dv[k]),
      .dv_o  (dv[k+1])
    );
  end

  // ------------------------ stage 71: signed normal and relative velocity
  logic signed [NVEC_W-1:0] nx_d;
  logic signed [NVEC_W-1:0] ny_d;
  logic signed [RV_W-1:0]   rvx_q;
  logic signed [RV_W-1:0]   rvy_q;

  always_comb begin
    nx_d = $signed({1'b0, dv[N_DIV].q_x});
    ny_d = $signed({1'b0, dv[N_DIV].q_y});
    if (side_q[ST_DIV_END].sx) begin
      nx_d = -nx_d;
    end
    if (side_q[ST_DIV_END].sy) begin
      ny_d = -ny_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rvx_q <= RV_W'(side_q[ST_DIV_END].v1x) - RV_W'(side_q[ST_DIV_END].v2x);
      rvy_q <= RV_W'(side_q[ST_DIV_END].v1y) - RV_W'(side_q[ST_DIV_END].v2y);
    end
  end

  // ---------------------------------- stages 72, 73: exact dot product
  logic signed [PROD_W-1:0] px_q;
  logic signed [PROD_W-1:0] py_q;
  logic signed [DOT_W-1:0]  dot_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q  <= PROD_W'(rvx_q) * PROD_W'(side_q[ST_N].nx);
      py_q  <= PROD_W'(rvy_q) * PROD_W'(side_q[ST_N].ny);
      dot_q <= DOT_W'(px_q) + DOT_W'(py_q);
    end
  end

  // ------------------------------ stage 74: speed, clamp, approach magnitude
  logic signed [SPD_W-1:0] spd;
  logic signed [SPD_W-1:0] lim;
  logic signed [SPD_W-1:0] spd_c;
  logic                    dot_pos;
  logic [MAG_W-1:0]        mag_q;
  outcome_e                outc_d;

  always_comb begin
    spd     = SPD_W'(dot_q >>> NORM_BITS);
    lim     = -$signed({{(SPD_W-MINSPD_W){1'b0}}, minspd_q});
    spd_c   = (spd > lim) ? lim : spd;
    dot_pos = !dot_q[DOT_W-1] && (dot_q != '0);
    outc_d  = side_q[ST_OUT-1].outcome;
    if ((side_q[ST_OUT-1].outcome == OUT_IMPULSE) && dot_pos) begin
      outc_d = OUT_SEPARATING;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q <= MAG_W'(-spd_c);
    end
  end

  // --------------------------------- stage 75: impulse r = mag*(1+e)/2
  logic [K_W-1:0]       kfac;
  logic [MAG_W+K_W-1:0] rprod;
  logic [RIMP_W-1:0]    r_q;

  always_comb begin
    kfac  = REST_ONE + {1'b0, rest_q};
    rprod = (MAG_W+K_W)'(mag_q) * (MAG_W+K_W)'(kfac);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q <= rprod[MAG_W+K_W-1:REST_W];
    end
  end

  // ------------------ stage 76: r * normal, split into two partial products
  logic signed [PPART_W-1:0] phx_q;
  logic signed [PPART_W-1:0] plx_q;
  logic signed [PPART_W-1:0] phy_q;
  logic signed [PPART_W-1:0] ply_q;
  logic signed [RPART_W:0]   r_hi;
  logic signed [RPART_W:0]   r_lo;

  assign r_hi = $signed({1'b0, r_q[RIMP_W-1:RPART_W]});
  assign r_lo = $signed({1'b0, r_q[RPART_W-1:0]});

  always_ff @(posedge clk_i) begin
    if (en) begin
      phx_q <= PPART_W'(r_hi) * PPART_W'(side_q[ST_OUT+1].nx);
      plx_q <= PPART_W'(r_lo) * PPART_W'(side_q[ST_OUT+1].nx);
      phy_q <= PPART_W'(r_hi) * PPART_W'(side_q[ST_OUT+1].ny);
      ply_q <= PPART_W'(r_lo) * PPART_W'(side_q[ST_OUT+1].ny);
    end
  end

  // ------------------------------ stage 77: velocity delta, floor shifted
  logic signed [DSUM_W-1:0] dsx;
  logic signed [DSUM_W-1:0] dsy;
  logic signed [DD_W-1:0]   ddx_q;
  logic signed [DD_W-1:0]   ddy_q;

  always_comb begin
    dsx = (DSUM_W'(phx_q) <<< RPART_W) + DSUM_W'(plx_q);
    dsy = (DSUM_W'(phy_q) <<< RPART_W) + DSUM_W'(ply_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ddx_q <= DD_W'(dsx >>> NORM_BITS);
      ddy_q <= DD_W'(dsy >>> NORM_BITS);
    end
  end

  // ----------------------------------- side line: velocities and flags
  // Shift the side line by one stage and drop in the fields computed along
  // the way.
  always_comb begin
    side_d[0]     = '0;
    side_d[0].v1x = in_beat_i.first_vel_x;
    side_d[0].v1y = in_beat_i.first_vel_y;
    side_d[0].v2x = in_beat_i.second_vel_x;
    side_d[0].v2y = in_beat_i.second_vel_y;
    for (int i = 1; i < PIPE_LAT; i++) begin
      side_d[i] = side_q[i-1];
    end
    side_d[1].sx           = dx_q[DIFF_W-1];
    side_d[1].sy           = dy_q[DIFF_W-1];
    side_d[1].outcome      = coinc ? OUT_COINCIDENT : OUT_IMPULSE;
    side_d[ST_AB].a        = nrm[N_NORM].a;
    side_d[ST_AB].b        = nrm[N_NORM].b;
    side_d[ST_N].nx        = nx_d;
    side_d[ST_N].ny        = ny_d;
    side_d[ST_OUT].outcome = outc_d;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < PIPE_LAT; i++) begin
        side_q[i] <= side_d[i];
      end
    end
  end

  // ------------------------------------------- result and output register
  out_beat_t res;
  side_t     last;

  assign last = side_q[PIPE_LAT-1];

  always_comb begin
    res.new_first_vel_x  = last.v1x;
    res.new_first_vel_y  = last.v1y;
    res.new_second_vel_x = last.v2x;
    res.new_second_vel_y = last.v2y;
    res.outcome          = last.outcome;
    if (last.outcome == OUT_IMPULSE) begin
      res.new_first_vel_x  = sat_word(VSUM_W'(last.v1x) + VSUM_W'(ddx_q));
      res.new_first_vel_y  = sat_word(VSUM_W'(last.v1y) + VSUM_W'(ddy_q));
      res.new_second_vel_x = sat_word(VSUM_W'(last.v2x) - VSUM_W'(ddx_q));
      res.new_second_vel_y = sat_word(VSUM_W'(last.v2y) - VSUM_W'(ddy_q));
    end
  end

  out_beat_t out_beat_q;
  out_beat_t skid_beat_q;
  logic      out_held;

  assign out_held = out_valid_q && out_stall_i;

  // Park the last stage's beat in the skid register when the output is held;
  // drain the skid register first once the output frees up.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_q      <= 1'b0;
    end else if (out_held) begin
      if (vld_q[PIPE_LAT-1] && !skid_q) begin
        skid_q <= 1'b1;
      end
    end else begin
      out_valid_q <= skid_q || vld_q[PIPE_LAT-1];
      skid_q      <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_held) begin
      if (vld_q[PIPE_LAT-1] && !skid_q) begin
        skid_beat_q <= res;
      end
    end else if (skid_q) begin
      out_beat_q <= skid_beat_q;
    end else begin
      out_beat_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // ------------------------------------------------------------ assertions
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_q) |-> $past(out_valid_o && out_stall_i))
    else $error("skid register filled while output was free");

  a_skid_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_q |-> out_valid_o)
    else $error("skid register full behind an empty output register");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(skid_q) |-> out_valid_o)
    else $error("skid beat lost on drain");

endmodule
`default_nettype wire

// ===== rtl/core/pcr_norm_cell.sv =====
// One normalizing cell: shift the separation left by a fixed step if the top is clear.
`timescale 1ns / 1ps
`default_nettype none
module pcr_norm_cell import pcr_pkg::*; #(
  parameter int unsigned SHIFT = 16
) (
  input  logic  clk_i,
  input  logic  en_i,
  input  norm_t nrm_i,
  output norm_t nrm_o
);

  norm_t nrm_d;
  norm_t nrm_q;

  always_comb begin
    nrm_d = nrm_i;
    if (nrm_i.m[NRM_W-1 -: SHIFT] == '0) begin
      nrm_d.a = nrm_i.a << SHIFT;
      nrm_d.b = nrm_i.b << SHIFT;
      nrm_d.m = nrm_i.m << SHIFT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nrm_q <= nrm_d;
    end
  end

  assign nrm_o = nrm_q;

endmodule
`default_nettype wire

// ===== rtl/core/pcr_sqrt_cell.sv =====
// One square root cell: settle one root bit from the next two radicand bits.
`timescale 1ns / 1ps
`default_nettype none
module pcr_sqrt_cell import pcr_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  sqrt_t sq_i,
  output sqrt_t sq_o
);

  logic [SREM_W-1:0] part;
  logic [SREM_W-1:0] trial;
  logic              ge;
  sqrt_t             sq_d;
  sqrt_t             sq_q;

  always_comb begin
    part      = {sq_i.rem[SREM_W-3:0], sq_i.rad[RAD_W-1 -: 2]};
    trial     = {{(SREM_W-ROOT_W-2){1'b0}}, sq_i.root, 2'b01};
    ge        = part >= trial;
    sq_d.rad  = {sq_i.rad[RAD_W-3:0], 2'b00};
    sq_d.rem  = ge ? part - trial : part;
    sq_d.root = {sq_i.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule
`default_nettype wire

// ===== rtl/core/pcr_div_cell.sv =====
// One divider cell: settle one quotient bit of both normal components.
`timescale 1ns / 1ps
`default_nettype none
module pcr_div_cell import pcr_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  div_t dv_i,
  output div_t dv_o
);

  logic [DREM_W-1:0] den;
  logic [DREM_W-1:0] diff_x;
  logic [DREM_W-1:0] diff_y;
  logic              ge_x;
  logic              ge_y;
  div_t              dv_d;
  div_t              dv_q;

  always_comb begin
    den          = {1'b0, dv_i.divisor};
    ge_x         = dv_i.rem_x >= den;
    ge_y         = dv_i.rem_y >= den;
    diff_x       = ge_x ? dv_i.rem_x - den : dv_i.rem_x;
    diff_y       = ge_y ? dv_i.rem_y - den : dv_i.rem_y;
    dv_d.rem_x   = {diff_x[DREM_W-2:0], 1'b0};
    dv_d.rem_y   = {diff_y[DREM_W-2:0], 1'b0};
    dv_d.q_x     = {dv_i.q_x[QUO_W-2:0], ge_x};
    dv_d.q_y     = {dv_i.q_y[QUO_W-2:0], ge_y};
    dv_d.divisor = dv_i.divisor;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q <= dv_d;
    end
  end

  assign dv_o = dv_q;

endmodule
`default_nettype wire
